### hw/rtl/gfa_pkg.sv
// ----------------------------------------------------------------------------
// gfa_pkg
// types and constants shared by the 2d gravity force accumulator
// ----------------------------------------------------------------------------
package gfa_pkg;

  typedef struct packed {
    logic signed [15:0] self_x;
    logic signed [15:0] self_y;
    logic [15:0]        self_mass;
    logic signed [15:0] other_x;
    logic signed [15:0] other_y;
    logic [15:0]        other_mass;
    logic               is_self;
    logic               last_body;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               coincident_seen;
    logic               saturated;
  } out_item_t;

  localparam logic signed [40:0] TERM_MAX = 41'sd549755813887;
  localparam logic signed [40:0] TERM_MIN = -41'sd549755813888;
  localparam logic signed [39:0] OUT_MAX  = 40'sd2147483647;
  localparam logic signed [39:0] OUT_MIN  = -40'sd2147483648;
  localparam logic [31:0]        GRAV_RESET = 32'd65536;
  localparam logic [38:0]        MAG_MAX = {39{1'b1}};

endpackage

### hw/rtl/gfa_mul.sv
// ----------------------------------------------------------------------------
// gfa_mul
// shared unsigned multiplier, 33 x 32 bits, registered product
// ----------------------------------------------------------------------------
module gfa_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [64:0] p
);

  always_ff @(posedge clk) begin
    p <= 65'(a) * 65'(b);
  end

endmodule

### hw/rtl/gravity_force_accumulator_2d.sv
// ----------------------------------------------------------------------------
// gravity_force_accumulator_2d
// net 2d newtonian pull on one body, accumulated over a run of pair items
// ----------------------------------------------------------------------------
// each input item on in_valid/in_ready pairs a target body with one other
// body. the pull g*m1*m2*d/|d|^3 is added to running 40-bit sums. on the item
// with last_body set, the clipped sums go out on out_valid/out_ready as one
// item and the sums and coincidence flag clear.
// a self item or a coincident pair goes from accept straight to the finish
// step. a full pair runs 5 multiply steps, 17 square root steps, then per
// axis 4 multiply steps, 2 setup steps, a 39-step restoring divide and 1
// accumulate step, then 1 finish step, all on one shared multiplier, with
// separate subtract/compare logic for root and divide. a term that clips
// skips its divide. in_ready is high only while idle. the result of a last
// item is registered at the finish step and sits in an output register, so
// the next run goes on while it waits; a last item stalls at its end only
// while that register is still full. cfg_we writes grav_const at once; the
// user must write grav_const only while idle; the block does not enforce it.
// rst (synchronous) clears sums, flag, output valid and sets g to 1.0.
// ----------------------------------------------------------------------------
module gravity_force_accumulator_2d
  import gfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MULA   = 9'b000000010,
    S_SQRT   = 9'b000000100,
    S_MULB   = 9'b000001000,
    S_DIVCHK = 9'b000010000,
    S_DIVB   = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_ACC    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state;
  logic [2:0]  mstep;
  logic        axis;
  logic [4:0]  sq_cnt;
  logic [5:0]  div_cnt;
  logic [31:0] grav_const;
  logic [15:0] ax, ay, m1, m2;
  logic        neg_x, neg_y, last;
  logic [31:0] sqx;
  logic [32:0] r2;
  logic [63:0] k;
  logic [16:0] root;
  logic [17:0] sq_rem;
  logic [33:0] sq_src;
  logic [49:0] r3;
  logic [47:0] lo, hi;
  logic [79:0] num;
  logic [49:0] drem;
  logic [38:0] dsrc, quo;
  logic        big;
  logic signed [39:0] sum_x, sum_y;
  logic        cflag;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;

  gfa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  logic signed [16:0] dx, dy;
  logic [15:0] aa;
  logic [19:0] sq_remn, sq_trial;
  logic [50:0] dtry;
  logic [38:0] mag;
  logic signed [40:0] term, acc_in, acc_sum;
  logic signed [39:0] acc_clip;
  logic emit;

  function automatic logic signed [31:0] clip32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > OUT_MAX) r = OUT_MAX[31:0];
    else if (v < OUT_MIN) r = OUT_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign dx = {in_data.other_x[15], in_data.other_x} - {in_data.self_x[15], in_data.self_x};
  assign dy = {in_data.other_y[15], in_data.other_y} - {in_data.self_y[15], in_data.self_y};
  assign aa = axis ? ay : ax;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MULA: begin
        case (mstep)
          3'd0: begin mul_a = 33'(ax); mul_b = 32'(ax); end
          3'd1: begin mul_a = 33'(ay); mul_b = 32'(ay); end
          3'd2: begin mul_a = 33'(m1); mul_b = 32'(m2); end
          default: begin mul_a = 33'(prod[31:0]); mul_b = grav_const; end
        endcase
      end
      S_MULB: begin
        case (mstep)
          3'd0: begin mul_a = r2; mul_b = 32'(root); end
          3'd1: begin mul_a = 33'(k[31:0]); mul_b = 32'(aa); end
          default: begin mul_a = 33'(k[63:32]); mul_b = 32'(aa); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sq_remn  = {sq_rem, sq_src[33:32]};
    sq_trial = {1'b0, root, 2'b01};
    dtry     = {drem, dsrc[38]};
    mag      = big ? MAG_MAX : quo;
    term     = $signed({2'b00, mag});
    acc_in   = (axis ? neg_y : neg_x) ? -term : term;
    acc_sum  = (axis ? {sum_y[39], sum_y} : {sum_x[39], sum_x}) + acc_in;
    if (acc_sum > TERM_MAX) acc_clip = TERM_MAX[39:0];
    else if (acc_sum < TERM_MIN) acc_clip = TERM_MIN[39:0];
    else acc_clip = acc_sum[39:0];
    emit = (state == S_FIN) && last && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mstep      <= '0;
      axis       <= 1'b0;
      sq_cnt     <= '0;
      div_cnt    <= '0;
      grav_const <= GRAV_RESET;
      sum_x      <= '0;
      sum_y      <= '0;
      cflag      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) grav_const <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ax    <= dx[16] ? 16'(-dx) : dx[15:0];
            ay    <= dy[16] ? 16'(-dy) : dy[15:0];
            neg_x <= dx[16];
            neg_y <= dy[16];
            m1    <= in_data.self_mass;
            m2    <= in_data.other_mass;
            last  <= in_data.last_body;
            mstep <= '0;
            axis  <= 1'b0;
            if (in_data.is_self) begin
              state <= S_FIN;
            end else if (dx == 17'sd0 && dy == 17'sd0) begin
              cflag <= 1'b1;
              state <= S_FIN;
            end else begin
              state <= S_MULA;
            end
          end
        end
        S_MULA: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1: sqx <= prod[31:0];
            3'd2: r2 <= {1'b0, sqx} + {1'b0, prod[31:0]};
            3'd4: begin
              k      <= prod[63:0];
              sq_src <= {1'b0, r2};
              root   <= '0;
              sq_rem <= '0;
              sq_cnt <= '0;
              state  <= S_SQRT;
            end
            default: ;
          endcase
        end
        S_SQRT: begin
          if (sq_remn >= sq_trial) begin
            sq_rem <= 18'(sq_remn - sq_trial);
            root   <= {root[15:0], 1'b1};
          end else begin
            sq_rem <= sq_remn[17:0];
            root   <= {root[15:0], 1'b0};
          end
          sq_src <= {sq_src[31:0], 2'b00};
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd16) begin
            mstep <= '0;
            state <= S_MULB;
          end
        end
        S_MULB: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1: r3 <= prod[49:0];
            3'd2: lo <= prod[47:0];
            3'd3: begin
              hi    <= prod[47:0];
              state <= S_DIVCHK;
            end
            default: ;
          endcase
        end
        S_DIVCHK: begin
          num   <= {hi, 32'b0} + 80'(lo);
          state <= S_DIVB;
        end
        S_DIVB: begin
          big     <= (num[79:25] >= {5'b0, r3});
          drem    <= num[74:25];
          dsrc    <= {num[24:0], 14'b0};
          quo     <= '0;
          div_cnt <= '0;
          state   <= (num[79:25] >= {5'b0, r3}) ? S_ACC : S_DIV;
        end
        S_DIV: begin
          if (dtry >= {1'b0, r3}) begin
            drem <= 50'(dtry - {1'b0, r3});
            quo  <= {quo[37:0], 1'b1};
          end else begin
            drem <= dtry[49:0];
            quo  <= {quo[37:0], 1'b0};
          end
          dsrc    <= {dsrc[37:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd38) state <= S_ACC;
        end
        S_ACC: begin
          if (axis) begin
            sum_y <= acc_clip;
            state <= S_FIN;
          end else begin
            sum_x <= acc_clip;
            axis  <= 1'b1;
            mstep <= '0;
            state <= S_MULB;
          end
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (emit) begin
            out_valid                <= 1'b1;
            out_data.force_x         <= clip32(sum_x);
            out_data.force_y         <= clip32(sum_y);
            out_data.coincident_seen <= cflag;
            out_data.saturated       <= (sum_x > OUT_MAX) || (sum_x < OUT_MIN) ||
                                        (sum_y > OUT_MAX) || (sum_y < OUT_MIN);
            sum_x <= '0;
            sum_y <= '0;
            cflag <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt <= 6'd38)
    else $error("divide ran past quotient width");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && sum_x == 40'sd0 && sum_y == 40'sd0 && !cflag)
    else $error("run state not cleared on emit");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 2d gravity force accumulator: directed pairs
// cover coincidence, self items, extreme positions, masses and g, and term
// and sum saturation; random runs of bodies follow under three idle mixes,
// a long output hold-off and a sender drain; every output item is compared
// field by field with a local fixed point predictor of the force sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import gfa_pkg::*;

  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          SETTLE = 150;
  localparam logic [63:0] MAG_LIM = 64'd549755813887;
  localparam longint      SUM_HI = 64'sd549755813887;
  localparam longint      SUM_LO = -64'sd549755813888;
  localparam longint      OUT_HI = 64'sd2147483647;
  localparam longint      OUT_LO = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  gravity_force_accumulator_2d uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] grav = GRAV_RESET;
  longint      acc_x = 0;
  longint      acc_y = 0;
  logic        coinc = 1'b0;
  out_item_t   expected_forces[$];

  int errors = 0;
  int cycles = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_req = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver with hold-off counted here
  always @(posedge clk) begin : rx_drive
    int hold_ack;
    int hold_cnt;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 40;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] pull_mag(input logic [63:0] k, input logic [63:0] a,
                                           input logic [63:0] r3);
    logic [127:0] num, q;
    num = ({64'd0, k} * {64'd0, a}) << 14;
    q = num / {64'd0, r3};
    if (q > {64'd0, MAG_LIM}) return MAG_LIM;
    return q[63:0];
  endfunction

  function automatic longint sat_add(input longint s, input longint t);
    longint v;
    v = s + t;
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  task automatic predict_force(input in_item_t it);
    int          dx, dy;
    logic [63:0] ax, ay, r2, r3, k, tx, ty;
    out_item_t   res;
    logic        clip;
    if (!it.is_self) begin
      dx = int'(it.other_x) - int'(it.self_x);
      dy = int'(it.other_y) - int'(it.self_y);
      if (dx == 0 && dy == 0) begin
        coinc = 1'b1;
      end else begin
        ax = 64'((dx < 0) ? -dx : dx);
        ay = 64'((dy < 0) ? -dy : dy);
        r2 = ax * ax + ay * ay;
        r3 = r2 * isqrt(r2);
        k = {32'd0, grav} * ({48'd0, it.self_mass} * {48'd0, it.other_mass});
        tx = pull_mag(k, ax, r3);
        ty = pull_mag(k, ay, r3);
        acc_x = sat_add(acc_x, (dx < 0) ? -longint'(tx) : longint'(tx));
        acc_y = sat_add(acc_y, (dy < 0) ? -longint'(ty) : longint'(ty));
      end
    end
    if (it.last_body) begin
      clip = 1'b0;
      if (acc_x > OUT_HI) begin res.force_x = 32'(OUT_HI); clip = 1'b1; end
      else if (acc_x < OUT_LO) begin res.force_x = 32'(OUT_LO); clip = 1'b1; end
      else res.force_x = 32'(acc_x);
      if (acc_y > OUT_HI) begin res.force_y = 32'(OUT_HI); clip = 1'b1; end
      else if (acc_y < OUT_LO) begin res.force_y = 32'(OUT_LO); clip = 1'b1; end
      else res.force_y = 32'(acc_y);
      res.coincident_seen = coinc;
      res.saturated = clip;
      expected_forces.push_back(res);
      acc_x = 0;
      acc_y = 0;
      coinc = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin : check_out
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected item", out_data.force_x, 32'd0);
      end else begin
        want = expected_forces.pop_front();
        if (out_data.force_x !== want.force_x)
          report_mismatch("force_x", out_data.force_x, want.force_x);
        if (out_data.force_y !== want.force_y)
          report_mismatch("force_y", out_data.force_y, want.force_y);
        if (out_data.coincident_seen !== want.coincident_seen)
          report_mismatch("coincident_seen", 32'(out_data.coincident_seen),
                          32'(want.coincident_seen));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_force(it);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
  endtask

  task automatic set_grav(input logic [31:0] g);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    grav = g;
  endtask

  function automatic in_item_t pair(input int sx, input int sy, input int sm,
                                    input int ox, input int oy, input int om,
                                    input bit self, input bit last);
    in_item_t it;
    it.self_x = 16'(sx); it.self_y = 16'(sy); it.self_mass = 16'(sm);
    it.other_x = 16'(ox); it.other_y = 16'(oy); it.other_mass = 16'(om);
    it.is_self = self; it.last_body = last;
    return it;
  endfunction

  function automatic in_item_t rand_pair(input bit last);
    in_item_t     it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(3) == 0) begin
      it.other_x = it.self_x + $signed(16'($urandom_range(64))) - 16'sd32;
      it.other_y = it.self_y + $signed(16'($urandom_range(64))) - 16'sd32;
    end
    if ($urandom_range(15) == 0) begin
      it.other_x = it.self_x;
      it.other_y = it.self_y;
    end
    if ($urandom_range(3) == 0) it.self_mass = 16'($urandom_range(1023));
    it.is_self = ($urandom_range(9) == 0);
    it.last_body = last;
    return it;
  endfunction

  task automatic test_directed;
    send_item(pair(0, 0, 256, 0, 0, 256, 0, 1));
    send_item(pair(100, -100, 256, 100, -100, 512, 1, 1));
    send_item(pair(-32768, -32768, 65535, 32767, 32767, 65535, 0, 0));
    send_item(pair(32767, 32767, 65535, -32768, -32768, 65535, 0, 1));
    send_item(pair(0, 0, 65535, 1, 0, 65535, 0, 0));
    send_item(pair(0, 0, 65535, 1, 0, 65535, 0, 0));
    send_item(pair(0, 0, 65535, 0, -1, 65535, 0, 1));
    send_item(pair(1000, 2000, 0, 3000, -4000, 65535, 0, 1));
    send_item(pair(0, 0, 256, 16384, 16384, 256, 0, 0));
    send_item(pair(0, 0, 256, 0, 0, 256, 1, 0));
    send_item(pair(5, 5, 256, 5, 5, 256, 0, 0));
    send_item(pair(0, 0, 256, -16384, 8192, 256, 0, 1));
    send_item(pair(7, 7, 300, 7, 7, 300, 1, 1));
    set_grav(32'hFFFFFFFF);
    send_item(pair(0, 0, 256, 32767, 0, 256, 0, 1));
    send_item(pair(-32768, 0, 65535, -32767, 1, 65535, 0, 1));
    set_grav(32'd0);
    send_item(pair(0, 0, 65535, 3, 4, 65535, 0, 1));
    set_grav(32'd1);
    send_item(pair(0, 0, 65535, 3, -4, 65535, 0, 1));
  endtask

  task automatic test_random_runs(input int runs);
    int n;
    for (int r = 0; r < runs; r++) begin
      n = ($urandom_range(7) == 0) ? 1 : int'($urandom_range(8, 2));
      for (int i = 0; i < n; i++) send_item(rand_pair(i == n - 1));
      if ($urandom_range(9) == 0) send_item(rand_pair(1'($urandom_range(1))));
    end
  endtask

  task automatic test_output_stall;
    hold_req++;
    for (int i = 0; i < 30; i++) send_item(rand_pair(1'($urandom_range(1))));
    send_item(rand_pair(1'b1));
    drain();
    for (int i = 0; i < 10; i++) send_item(rand_pair(1'b1));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int m = 0; m < 3; m++) begin
      tx_idle = (m == 0) ? 17 : (m == 1) ? 61 : 0;
      rx_idle = (m == 0) ? 61 : (m == 1) ? 17 : 0;
      set_grav(GRAV_RESET);
      test_random_runs(30);
      set_grav($urandom);
      test_random_runs(30);
      set_grav($urandom_range(255));
      test_random_runs(30);
    end
    test_output_stall();
    set_grav(32'hFFFFFFFF);
    test_random_runs(10);
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/gfa_pkg.sv
hw/rtl/gfa_mul.sv
hw/rtl/gravity_force_accumulator_2d.sv
test/testbench.sv
